// ----- sv/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the point-to-screen locator
// Holds the rectangle record, command and state codes, and the datapath
// widths used by the sequencer, the distance unit and the table memory.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int CMD_W     = 2;
	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 15;
	localparam int ENTRY_W   = 8;
	localparam int SEL_W     = 3;
	localparam int COUNT_W   = 4;
	localparam int CFG_IDX_W = 2;

	// Edge offsets reach about +/-98k, so 18 signed bits hold them.
	localparam int DIFF_W = 18;
	localparam int ABS_W  = DIFF_W - 1;
	localparam int DIST_W = ABS_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] FB_WIDTH_RESET  = 15'd1920;
	localparam logic [SIZE_W-1:0] FB_HEIGHT_RESET = 15'd1080;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_LOCATE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DECIDE,
		ST_READ,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
	} rect_t;

	typedef struct packed {
		logic [SEL_W-1:0] sel;
		rect_t            rect;
		logic             full;
	} res_t;

	typedef struct packed {
		logic              contains;
		logic [DIST_W-1:0] corner_dist;
		rect_t             rect;
	} dist_res_t;

endpackage

// ----- sv/pts_ram.sv -----
// ----------------------------------------------------------------------------
// pts_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/pts_dist.sv -----
// ----------------------------------------------------------------------------
// pts_dist: shared rectangle distance unit
// Registers the signed edge offsets of one rectangle against the point, then
// derives containment and the smallest corner Manhattan distance from them.
// ----------------------------------------------------------------------------
module pts_dist (
	input  logic                              clk,
	input  logic                              load,
	input  pts_pkg::rect_t                    rect,
	input  logic signed [pts_pkg::COORD_W-1:0] pt_x,
	input  logic signed [pts_pkg::COORD_W-1:0] pt_y,
	output pts_pkg::dist_res_t                res
);

	localparam int DW = pts_pkg::DIFF_W;
	localparam int AW = pts_pkg::ABS_W;
	localparam int SW = pts_pkg::DIST_W;

	logic signed [DW-1:0] px_e, py_e, x_e, y_e;
	logic signed [DW-1:0] w_e, h_e;
	logic signed [DW-1:0] sl, sr, st, sb;

	logic signed [DW-1:0] sl_s1, sr_s1, st_s1, sb_s1;
	pts_pkg::rect_t       rect_s1;

	logic [AW-1:0] dl, dr, dt, db;
	logic [SW-1:0] c0, c1, c2, c3, m01, m23;

	always_comb begin
		px_e = DW'(pt_x);
		py_e = DW'(pt_y);
		x_e  = DW'(rect.x);
		y_e  = DW'(rect.y);
		w_e  = DW'(rect.w);
		h_e  = DW'(rect.h);
		// Non-negative offsets mean the point lies on the inner side of that edge.
		sl = px_e - x_e;
		sr = x_e + w_e - DW'(1) - px_e;
		st = py_e - y_e;
		sb = y_e + h_e - DW'(1) - py_e;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sl_s1   <= sl;
			sr_s1   <= sr;
			st_s1   <= st;
			sb_s1   <= sb;
			rect_s1 <= rect;
		end
	end

	always_comb begin
		dl  = sl_s1[DW-1] ? AW'(-sl_s1) : sl_s1[AW-1:0];
		dr  = sr_s1[DW-1] ? AW'(-sr_s1) : sr_s1[AW-1:0];
		dt  = st_s1[DW-1] ? AW'(-st_s1) : st_s1[AW-1:0];
		db  = sb_s1[DW-1] ? AW'(-sb_s1) : sb_s1[AW-1:0];
		c0  = SW'(dl) + SW'(dt);
		c1  = SW'(dr) + SW'(dt);
		c2  = SW'(dr) + SW'(db);
		c3  = SW'(dl) + SW'(db);
		m01 = (c1 < c0) ? c1 : c0;
		m23 = (c3 < c2) ? c3 : c2;
		res.corner_dist = (m23 < m01) ? m23 : m01;
		res.contains    = !sl_s1[DW-1] && !sr_s1[DW-1] && !st_s1[DW-1] && !sb_s1[DW-1];
		res.rect        = rect_s1;
	end

endmodule

// ----- sv/point_to_screen_locator_top.sv -----
// ----------------------------------------------------------------------------
// point_to_screen_locator_top: screen table with point lookup
// Stores screen rectangles, answers clear, append, locate and read commands,
// and falls back to a configured stand-in screen while the table is empty.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   in      | in_valid / in_stall   | command, pos_x, pos_y, width, height, entry_index
//   out     | out_valid / out_stall | screen_index, rect_{x,y,width,height}, count, full
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item holds the sequencer: clear, append, a read past the count and any command
// on an empty table go from idle straight to finish; a read of a stored entry passes
// the read state first, and a locate runs load and decide for each stored entry:
// each entry takes one table read and one distance stage, and a containing entry
// ends the scan early. Output loads in finish, later while a stalled result fills it.
// Reset clears the count and the sequencer; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module point_to_screen_locator_top #(
	parameter int unsigned MAX_SCREENS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pts_pkg::CMD_W-1:0]           command,
	input  logic signed [pts_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [pts_pkg::COORD_W-1:0]  pos_y,
	input  logic [pts_pkg::SIZE_W-1:0]          width,
	input  logic [pts_pkg::SIZE_W-1:0]          height,
	input  logic [pts_pkg::ENTRY_W-1:0]         entry_index,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pts_pkg::SEL_W-1:0]           screen_index,
	output logic signed [pts_pkg::COORD_W-1:0]  rect_x,
	output logic signed [pts_pkg::COORD_W-1:0]  rect_y,
	output logic [pts_pkg::SIZE_W-1:0]          rect_width,
	output logic [pts_pkg::SIZE_W-1:0]          rect_height,
	output logic [pts_pkg::COUNT_W-1:0]         screen_count,
	output logic                                table_full,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pts_pkg::SIZE_W-1:0]          cfg_data
);

	// Table addresses, and a count that can also hold MAX_SCREENS itself.
	localparam int IDX_W  = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
	localparam int CNT_W  = $clog2(MAX_SCREENS + 1);
	localparam int CMP_W  = (CNT_W > pts_pkg::ENTRY_W) ? CNT_W : pts_pkg::ENTRY_W;
	localparam int RECT_W = $bits(pts_pkg::rect_t);

	pts_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] total_q, total_d;
	logic [IDX_W-1:0] scan_q, scan_d;
	logic             out_valid_q;

	logic [pts_pkg::SIZE_W-1:0] fb_width_q, fb_height_q;

	// Working registers of the current transaction.
	pts_pkg::res_t                     res_q, res_d;
	logic signed [pts_pkg::COORD_W-1:0] px_q, px_d, py_q, py_d;
	logic [pts_pkg::DIST_W-1:0]         best_dist_q, best_dist_d;
	logic [IDX_W-1:0]                   best_idx_q, best_idx_d;
	pts_pkg::rect_t                     best_rect_q, best_rect_d;

	// Output register.
	pts_pkg::res_t               out_res_q;
	logic [pts_pkg::COUNT_W-1:0] out_count_q;

	logic             in_accept;
	logic             out_load;
	logic             ram_we;
	logic [IDX_W-1:0] ram_raddr;
	logic [RECT_W-1:0] ram_rdata;
	logic             dist_load;
	logic             table_is_full;
	logic             last_entry;
	logic             better;
	logic [CNT_W-1:0] used_count;

	pts_pkg::rect_t     new_rect;
	pts_pkg::rect_t     fallback_rect;
	pts_pkg::rect_t     table_rect;
	pts_pkg::dist_res_t dist_res;

	assign in_stall  = (state_q != pts_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign new_rect      = '{x: pos_x, y: pos_y, w: width, h: height};
	assign fallback_rect = '{x: '0, y: '0, w: fb_width_q, h: fb_height_q};
	assign table_rect    = pts_pkg::rect_t'(ram_rdata);

	assign table_is_full = (total_q == CNT_W'(MAX_SCREENS));
	assign last_entry    = ((CNT_W'(scan_q) + CNT_W'(1)) == total_q);
	assign better        = (dist_res.corner_dist < best_dist_q);
	assign used_count    = (total_q == '0) ? CNT_W'(1) : total_q;

	// The table itself; entries at or above the count are never read.
	pts_ram #(
		.WIDTH (RECT_W),
		.DEPTH (MAX_SCREENS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (total_q[IDX_W-1:0]),
		.wdata (new_rect),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The distance unit takes the entry straight from the RAM read register.
	pts_dist u_dist (
		.clk  (clk),
		.load (dist_load),
		.rect (table_rect),
		.pt_x (px_q),
		.pt_y (py_q),
		.res  (dist_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pts_pkg::ST_IDLE;
			total_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
			fb_width_q  <= pts_pkg::FB_WIDTH_RESET;
			fb_height_q <= pts_pkg::FB_HEIGHT_RESET;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			scan_q  <= scan_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// Indexes past the two registers are ignored.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pts_pkg::CFG_FB_WIDTH) begin
					fb_width_q <= cfg_data;
				end else if (cfg_index == pts_pkg::CFG_FB_HEIGHT) begin
					fb_height_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q       <= res_d;
		px_q        <= px_d;
		py_q        <= py_d;
		best_dist_q <= best_dist_d;
		best_idx_q  <= best_idx_d;
		best_rect_q <= best_rect_d;
		if (out_load) begin
			out_res_q   <= res_q;
			out_count_q <= pts_pkg::COUNT_W'(used_count);
		end
	end

	// Sequencer: next state, table access and result assembly.
	always_comb begin
		state_d     = state_q;
		total_d     = total_q;
		scan_d      = scan_q;
		res_d       = res_q;
		px_d        = px_q;
		py_d        = py_q;
		best_dist_d = best_dist_q;
		best_idx_d  = best_idx_q;
		best_rect_d = best_rect_q;
		ram_we      = 1'b0;
		ram_raddr   = scan_q;
		dist_load   = 1'b0;
		out_load    = 1'b0;

		case (state_q)
			pts_pkg::ST_IDLE: begin
				if (in_accept) begin
					px_d    = pos_x;
					py_d    = pos_y;
					res_d   = '0;
					state_d = pts_pkg::ST_FINISH;
					case (pts_pkg::cmd_t'(command))
						pts_pkg::CMD_CLEAR: begin
							total_d = '0;
						end
						pts_pkg::CMD_APPEND: begin
							// A rectangle with no area is skipped silently.
							if (width != '0 && height != '0) begin
								if (table_is_full) begin
									res_d.full = 1'b1;
								end else begin
									ram_we  = 1'b1;
									total_d = total_q + CNT_W'(1);
								end
							end
						end
						pts_pkg::CMD_LOCATE: begin
							if (total_q == '0) begin
								res_d.rect = fallback_rect;
							end else begin
								scan_d      = '0;
								ram_raddr   = '0;
								best_dist_d = '1;
								best_idx_d  = '0;
								state_d     = pts_pkg::ST_LOAD;
							end
						end
						pts_pkg::CMD_READ: begin
							res_d.sel = pts_pkg::SEL_W'(entry_index);
							if (total_q == '0) begin
								if (entry_index == '0) begin
									res_d.rect = fallback_rect;
								end
							end else if (CMP_W'(entry_index) < CMP_W'(total_q)) begin
								ram_raddr = IDX_W'(entry_index);
								state_d   = pts_pkg::ST_READ;
							end
						end
						default: begin
							state_d = pts_pkg::ST_FINISH;
						end
					endcase
				end
			end
			pts_pkg::ST_LOAD: begin
				dist_load = 1'b1;
				state_d   = pts_pkg::ST_DECIDE;
			end
			pts_pkg::ST_DECIDE: begin
				if (dist_res.contains) begin
					res_d.sel  = pts_pkg::SEL_W'(scan_q);
					res_d.rect = dist_res.rect;
					state_d    = pts_pkg::ST_FINISH;
				end else begin
					// Strictly smaller only, so the earliest entry keeps a tie.
					if (better) begin
						best_dist_d = dist_res.corner_dist;
						best_idx_d  = scan_q;
						best_rect_d = dist_res.rect;
					end
					if (last_entry) begin
						res_d.sel  = pts_pkg::SEL_W'(better ? scan_q : best_idx_q);
						res_d.rect = better ? dist_res.rect : best_rect_q;
						state_d    = pts_pkg::ST_FINISH;
					end else begin
						scan_d    = scan_q + IDX_W'(1);
						ram_raddr = scan_q + IDX_W'(1);
						state_d   = pts_pkg::ST_LOAD;
					end
				end
			end
			pts_pkg::ST_READ: begin
				res_d.rect = table_rect;
				state_d    = pts_pkg::ST_FINISH;
			end
			pts_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = pts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pts_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign screen_index = out_res_q.sel;
	assign rect_x       = out_res_q.rect.x;
	assign rect_y       = out_res_q.rect.y;
	assign rect_width   = out_res_q.rect.w;
	assign rect_height  = out_res_q.rect.h;
	assign screen_count = out_count_q;
	assign table_full   = out_res_q.full;

	// The count never passes the table depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_SCREENS))
		else $error("screen count exceeds table depth");

	// A scan only evaluates entries that are stored.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pts_pkg::ST_DECIDE) |-> (CNT_W'(scan_q) < total_q))
		else $error("locate scan past stored entries");

	// Every accepted transaction moves the sequencer out of idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q != pts_pkg::ST_IDLE))
		else $error("accepted transaction left no work");

	// A new result appears only when the sequencer has finished one.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pts_pkg::ST_FINISH))
		else $error("result loaded outside finish");

endmodule
